@@ hdl/udc_pkg.sv @@
// ----------------------------------------------------------------------------
// udc_pkg
// Shared types and constants of the ultrasonic door controller.
// ----------------------------------------------------------------------------
package udc_pkg;

  localparam int ECHO_W   = 16;
  localparam int CM_W     = 11;
  localparam int CM_MAX   = 1123;
  localparam int PROD_W   = 25;
  localparam int ECHO_MUL = 343;

  // counts * 343 / 20000: drop 5 bits (20000 = 32 * 625), then a
  // reciprocal of 625 over 30 fractional bits
  localparam int ECHO_PRE_SH = 5;
  localparam int RECIP_MUL   = 1717987;
  localparam int RECIP_SH    = 30;
  localparam int RECIP_W     = 41;

  localparam int PAUSE_W  = 10;
  localparam int RUN_W    = 7;
  localparam int FREQ_W   = 10;
  localparam int DUTY_W   = 6;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic fast;
    logic slow;
  } btn_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_NEAR   = 3'd0,
    REG_CLOSE_NEAR  = 3'd1,
    REG_FAR         = 3'd2,
    REG_OPEN_PAUSE  = 3'd3,
    REG_CLOSE_PAUSE = 3'd4,
    REG_IDLE_PAUSE  = 3'd5
  } cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_STOP  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } motor_cmd_t;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_SLOW = 2'd1,
    MODE_FAST = 2'd2
  } speed_mode_t;

  localparam logic [RUN_W-1:0]  RUN_INIT  = 7'd30;
  localparam logic [RUN_W-1:0]  RUN_SLOW  = 7'd100;
  localparam logic [RUN_W-1:0]  RUN_FAST  = 7'd8;
  localparam logic [FREQ_W-1:0] FREQ_HIGH = 10'd940;
  localparam logic [FREQ_W-1:0] FREQ_LOW  = 10'd740;
  localparam logic [DUTY_W-1:0] DUTY_INIT = 6'd33;
  localparam logic [DUTY_W-1:0] DUTY_SLOW = 6'd35;
  localparam logic [DUTY_W-1:0] DUTY_FAST = 6'd60;

endpackage

@@ hdl/udc_front.sv @@
// ----------------------------------------------------------------------------
// udc_front
// Echo intake: scales counts to centimetres, sums each group of samples and
// queues the group total with the button states of its last sample.
// ----------------------------------------------------------------------------
module udc_front import udc_pkg::*; #(
  parameter int SAMPLES = 10,
  parameter int SUM_W   = 14,
  parameter int DEPTH   = 4,
  parameter int LVL_W   = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [LVL_W-1:0]     q_level,
  output logic                 q_push,
  output logic [SUM_W-1:0]     q_sum,
  output btn_t                 q_btn
);

  localparam int CNT_W = $clog2(SAMPLES + 1);

  logic [CNT_W-1:0]   sample_count;
  logic               s1_valid;
  logic               s1_last;
  btn_t               s1_btn;
  logic [PROD_W-1:0]  s1_prod;
  logic [SUM_W-1:0]   distance_sum;
  logic [RECIP_W-1:0] cm_full;
  logic [CM_W-1:0]    cm;
  logic [SUM_W-1:0]   sum_next;
  logic               take;
  logic               pending;

  assign pending  = s1_valid & s1_last;
  assign s_tready = ({1'b0, q_level} + {{LVL_W{1'b0}}, pending}) < (LVL_W + 1)'(DEPTH);
  assign take     = s_tvalid & s_tready;

  assign cm_full  = RECIP_W'(s1_prod[PROD_W-1:ECHO_PRE_SH]) * RECIP_W'(RECIP_MUL);
  assign cm       = cm_full[RECIP_SH +: CM_W];
  assign sum_next = distance_sum + SUM_W'(cm);

  assign q_push = pending;
  assign q_sum  = sum_next;
  assign q_btn  = s1_btn;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      s1_valid     <= 1'b0;
      s1_last      <= 1'b0;
      distance_sum <= '0;
    end else begin
      s1_valid <= take;
      if (take) begin
        s1_prod     <= PROD_W'(s_tdata[ECHO_W-1:0]) * PROD_W'(ECHO_MUL);
        s1_btn.slow <= s_tdata[ECHO_W];
        s1_btn.fast <= s_tdata[ECHO_W+1];
        s1_last     <= (sample_count == CNT_W'(SAMPLES - 1));
        if (sample_count == CNT_W'(SAMPLES - 1)) begin
          sample_count <= '0;
        end else begin
          sample_count <= sample_count + 1'b1;
        end
      end
      if (s1_valid) begin
        distance_sum <= s1_last ? '0 : sum_next;
      end
    end
  end

endmodule

@@ hdl/udc_fifo.sv @@
// ----------------------------------------------------------------------------
// udc_fifo
// Short queue of group totals between intake and door decision.
// ----------------------------------------------------------------------------
module udc_fifo import udc_pkg::*; #(
  parameter int SUM_W = 14,
  parameter int DEPTH = 4,
  parameter int LVL_W = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [SUM_W-1:0] push_sum,
  input  btn_t             push_btn,
  input  logic             pop,
  output logic [SUM_W-1:0] head_sum,
  output btn_t             head_btn,
  output logic [LVL_W-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SUM_W-1:0] sum_mem [DEPTH];
  btn_t             btn_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign head_sum = sum_mem[rd_ptr];
  assign head_btn = btn_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      sum_mem[wr_ptr] <= push_sum;
      btn_mem[wr_ptr] <= push_btn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      level <= level + LVL_W'(push) - LVL_W'(pop);
    end
  end

endmodule

@@ hdl/udc_back.sv @@
// ----------------------------------------------------------------------------
// udc_back
// Door decision: mean distance, speed mode, door state and the result
// register, plus the threshold and pause registers.
// ----------------------------------------------------------------------------
module udc_back import udc_pkg::*; #(
  parameter int SAMPLES = 10,
  parameter int SUM_W   = 14,
  parameter int LVL_W   = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [LVL_W-1:0]      q_level,
  input  logic [SUM_W-1:0]      q_sum,
  input  btn_t                  q_btn,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // mean by reciprocal multiplication, exact over the whole sum range
  localparam int DIV_SH  = SUM_W + $clog2(SAMPLES);
  localparam int DIV_MUL = (2**DIV_SH + SAMPLES - 1) / SAMPLES;
  localparam int DIV_W   = 2 * SUM_W + 1;

  logic [CM_W-1:0]    open_near_cm;
  logic [CM_W-1:0]    close_near_cm;
  logic [CM_W-1:0]    far_cm;
  logic [PAUSE_W-1:0] open_pause_ms;
  logic [PAUSE_W-1:0] close_pause_ms;
  logic [PAUSE_W-1:0] idle_pause_ms;

  speed_mode_t        speed_mode;
  speed_mode_t        speed_mode_next;
  logic               door_open;
  logic               door_open_next;
  logic [DIV_W-1:0]   mean_full;
  logic [CM_W-1:0]    mean_cm;
  motor_cmd_t         cmd;
  logic [RUN_W-1:0]   run;
  logic [FREQ_W-1:0]  freq;
  logic [DUTY_W-1:0]  duty;
  logic [PAUSE_W-1:0] pause;

  assign q_pop     = (q_level != '0) & (~m_tvalid | m_tready);
  assign mean_full = DIV_W'(q_sum) * DIV_W'(DIV_MUL);
  assign mean_cm   = CM_W'(mean_full >> DIV_SH);

  always_comb begin
    speed_mode_next = speed_mode;
    if (q_btn.slow) speed_mode_next = MODE_SLOW;
    if (q_btn.fast) speed_mode_next = MODE_FAST;
    case (speed_mode_next)
      MODE_SLOW: begin
        run = RUN_SLOW; freq = FREQ_HIGH; duty = DUTY_SLOW;
      end
      MODE_FAST: begin
        run = RUN_FAST; freq = FREQ_LOW; duty = DUTY_FAST;
      end
      default: begin
        run = RUN_INIT; freq = FREQ_HIGH; duty = DUTY_INIT;
      end
    endcase
    door_open_next = door_open;
    if (mean_cm >= open_near_cm && mean_cm <= far_cm && !door_open) begin
      cmd            = CMD_OPEN;
      pause          = open_pause_ms;
      door_open_next = 1'b1;
    end else if ((mean_cm < close_near_cm || mean_cm > far_cm) && door_open) begin
      cmd            = CMD_CLOSE;
      pause          = close_pause_ms;
      door_open_next = 1'b0;
    end else begin
      cmd   = CMD_STOP;
      run   = '0;
      pause = idle_pause_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_near_cm   <= CM_W'(11);
      close_near_cm  <= CM_W'(10);
      far_cm         <= CM_W'(500);
      open_pause_ms  <= PAUSE_W'(650);
      close_pause_ms <= PAUSE_W'(550);
      idle_pause_ms  <= PAUSE_W'(400);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OPEN_NEAR:   open_near_cm   <= cfg_data;
        REG_CLOSE_NEAR:  close_near_cm  <= cfg_data;
        REG_FAR:         far_cm         <= cfg_data;
        REG_OPEN_PAUSE:  open_pause_ms  <= cfg_data[PAUSE_W-1:0];
        REG_CLOSE_PAUSE: close_pause_ms <= cfg_data[PAUSE_W-1:0];
        REG_IDLE_PAUSE:  idle_pause_ms  <= cfg_data[PAUSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_mode <= MODE_INIT;
      door_open  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (q_pop) begin
        speed_mode <= speed_mode_next;
        door_open  <= door_open_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= {1'b0, duty, freq, door_open_next, pause, run, cmd, mean_cm};
    end
  end

endmodule

@@ hdl/ultrasonic_door_controller.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_door_controller
// Averages ultrasonic echo readings and decides door motor commands.
// ----------------------------------------------------------------------------
// Takes one echo count per cycle and gives one result for every group of
// SAMPLES_PER_READING counts. The scale multiply is registered first, the
// group sum is then written to the queue, and the door decision is registered
// into the result register when its queue entry is popped. The
// intake runs at one count per cycle as long as the decision queue has room;
// a stalled result only halts intake once QUEUE_DEPTH group totals wait.
// Configuration writes are taken every cycle.
module ultrasonic_door_controller import udc_pkg::*; #(
  parameter int SAMPLES_PER_READING = 10,
  parameter int QUEUE_DEPTH         = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // echo_count, slow_button, fast_button
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // distance_cm, motor_cmd, run_ms,
                                           // pause_ms, is_open, pwm_freq_hz,
                                           // pwm_duty_pct
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = $clog2(SAMPLES_PER_READING * CM_MAX + 1);
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic             q_push;
  logic             q_pop;
  logic [SUM_W-1:0] push_sum;
  btn_t             push_btn;
  logic [SUM_W-1:0] head_sum;
  btn_t             head_btn;
  logic [LVL_W-1:0] q_level;

  assign cfg_ready = 1'b1;

  udc_front #(
    .SAMPLES (SAMPLES_PER_READING),
    .SUM_W   (SUM_W),
    .DEPTH   (QUEUE_DEPTH),
    .LVL_W   (LVL_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_sum    (push_sum),
    .q_btn    (push_btn)
  );

  udc_fifo #(
    .SUM_W (SUM_W),
    .DEPTH (QUEUE_DEPTH),
    .LVL_W (LVL_W)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_sum (push_sum),
    .push_btn (push_btn),
    .pop      (q_pop),
    .head_sum (head_sum),
    .head_btn (head_btn),
    .level    (q_level)
  );

  udc_back #(
    .SAMPLES (SAMPLES_PER_READING),
    .SUM_W   (SUM_W),
    .LVL_W   (LVL_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_level   (q_level),
    .q_sum     (head_sum),
    .q_btn     (head_btn),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
